>>> hw/rtl/lfu_pkg.sv
// Shared constants and helpers for the LFU page replacement block.
// No dependencies; imported by lfu_page_replacement.
package lfu_pkg;

    localparam int FRAMES    = 16;
    localparam int USE_BITS  = 16;
    localparam int PAGE_W    = 32;
    localparam int FAULT_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 5;

    // Frame index width and a count wide enough to hold FRAMES itself.
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int LIM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [USE_BITS-1:0] uses_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam uses_t USE_MAX   = {USE_BITS{1'b1}};
    localparam uses_t USE_FIRST = uses_t'(1);

    // Low SLOT_W bits of a frame index, zero-extended if the index is narrower.
    function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/lfu_page_replacement.sv
// LFU page replacement engine: top level with frame store and scan sequencer.
// Depends on lfu_pkg for widths, constants and the slot helper.
//
// Usage: one page reference item enters on in_valid/in_stall with page_address.
// The block holds in_stall high while it works on an item. It scans the
// occupied frames one per cycle through a single read port, looking for a
// match and, at the same time, for the frame with the lowest use count
// (lowest index on ties). A hit ends the scan at the matching frame; a miss
// scans all occupied frames. An update step then applies the update and
// loads the result register. The result item is held in an output register,
// so a new reference can be accepted while the previous result still waits.
// If the receiver stalls and the next result is ready, the block waits in its
// update step until the register is free; nothing is lost or repeated.
// Reset (rst_n low) empties the frame set, clears the fault total and sets
// frames_in_use to 16. cfg_we writes frames_in_use; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module lfu_page_replacement
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lfu_pkg::PAGE_W-1:0] page_address,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic                       fault,
    output logic                       evicted_valid,
    output logic [lfu_pkg::SLOT_W-1:0] slot,
    output logic [lfu_pkg::PAGE_W-1:0] evicted_page,
    output logic [lfu_pkg::FAULT_W-1:0] fault_total
);
    import lfu_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    // Frame store: one read and one write port each, read data registered.
    page_t page_mem [FRAMES];
    uses_t uses_mem [FRAMES];
    page_t page_rd_reg;
    uses_t uses_rd_reg;

    logic [1:0]          state_reg, state_next;
    logic [CFG_W-1:0]    limit_cfg_reg;
    page_t               page_reg, page_next;
    cnt_t                issue_idx_reg, issue_idx_next;
    logic                rd_vld_reg, rd_vld_next;
    idx_t                rd_idx_reg, rd_idx_next;
    logic                found_reg, found_next;
    idx_t                hit_idx_reg, hit_idx_next;
    uses_t               hit_uses_reg, hit_uses_next;
    idx_t                min_idx_reg, min_idx_next;
    uses_t               min_uses_reg, min_uses_next;
    page_t               min_page_reg, min_page_next;
    cnt_t                filled_reg, filled_next;
    logic [FAULT_W-1:0]  faults_reg, faults_next;

    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic                evicted_reg, evicted_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    page_t               evicted_page_reg, evicted_page_next;

    logic                rd_en;
    logic                wr_en;
    logic                wr_page_en;
    idx_t                wr_idx;
    uses_t               wr_uses;

    logic [LIM_W-1:0]    limit_eff;
    logic [LIM_W-1:0]    limit_raw;
    logic [LIM_W-1:0]    filled_ext;
    logic                out_free;

    // Effective limit: the register clamped into 1..FRAMES.
    always_comb
    begin
        limit_raw  = LIM_W'(limit_cfg_reg);
        filled_ext = LIM_W'(filled_reg);
        if (limit_raw == '0)
        begin
            limit_eff = LIM_W'(1);
        end
        else if (limit_raw > LIM_W'(FRAMES))
        begin
            limit_eff = LIM_W'(FRAMES);
        end
        else
        begin
            limit_eff = limit_raw;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        page_next         = page_reg;
        issue_idx_next    = issue_idx_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        found_next        = found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_uses_next     = hit_uses_reg;
        min_idx_next      = min_idx_reg;
        min_uses_next     = min_uses_reg;
        min_page_next     = min_page_reg;
        filled_next       = filled_reg;
        faults_next       = faults_reg;
        out_valid_next    = out_valid_reg && out_stall;
        hit_next          = hit_reg;
        evicted_next      = evicted_reg;
        slot_next         = slot_reg;
        evicted_page_next = evicted_page_reg;
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        wr_page_en        = 1'b0;
        wr_idx            = hit_idx_reg;
        wr_uses           = USE_FIRST;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    page_next      = page_address;
                    issue_idx_next = '0;
                    found_next     = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the next frame read while frames remain.
                if (issue_idx_reg < filled_reg)
                begin
                    rd_en          = 1'b1;
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + cnt_t'(1);
                end

                // Examine the frame read in the previous cycle.
                if (rd_vld_reg)
                begin
                    if (page_rd_reg == page_reg)
                    begin
                        found_next    = 1'b1;
                        hit_idx_next  = rd_idx_reg;
                        hit_uses_next = uses_rd_reg;
                        rd_vld_next   = 1'b0;
                        state_next    = S_UPDATE;
                    end
                    else if (rd_idx_reg == '0 || uses_rd_reg < min_uses_reg)
                    begin
                        min_idx_next  = rd_idx_reg;
                        min_uses_next = uses_rd_reg;
                        min_page_next = page_rd_reg;
                    end
                end
                else if (issue_idx_reg >= filled_reg)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (found_reg)
                    begin
                        wr_idx            = hit_idx_reg;
                        wr_uses           = (hit_uses_reg != USE_MAX)
                                            ? hit_uses_reg + uses_t'(1) : hit_uses_reg;
                        hit_next          = 1'b1;
                        evicted_next      = 1'b0;
                        slot_next         = to_slot(hit_idx_reg);
                        evicted_page_next = '0;
                    end
                    else
                    begin
                        wr_page_en = 1'b1;
                        wr_uses    = USE_FIRST;
                        hit_next   = 1'b0;
                        if (faults_reg != {FAULT_W{1'b1}})
                        begin
                            faults_next = faults_reg + FAULT_W'(1);
                        end
                        if (filled_ext < limit_eff)
                        begin
                            // Free frame available: fill the next one in order.
                            wr_idx            = filled_reg[IDX_W-1:0];
                            filled_next       = filled_reg + cnt_t'(1);
                            evicted_next      = 1'b0;
                            evicted_page_next = '0;
                        end
                        else
                        begin
                            // All allowed frames taken: replace the least used.
                            wr_idx            = min_idx_reg;
                            evicted_next      = 1'b1;
                            evicted_page_next = min_page_reg;
                        end
                        slot_next = to_slot(wr_idx);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Frame store ports.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            page_rd_reg <= page_mem[issue_idx_reg[IDX_W-1:0]];
            uses_rd_reg <= uses_mem[issue_idx_reg[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            uses_mem[wr_idx] <= wr_uses;
            if (wr_page_en)
            begin
                page_mem[wr_idx] <= page_reg;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_cfg_reg <= CFG_W'(16);
            rd_vld_reg    <= 1'b0;
            filled_reg    <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            filled_reg    <= filled_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            if (cfg_we)
            begin
                limit_cfg_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        page_reg         <= page_next;
        issue_idx_reg    <= issue_idx_next;
        rd_idx_reg       <= rd_idx_next;
        hit_idx_reg      <= hit_idx_next;
        hit_uses_reg     <= hit_uses_next;
        min_idx_reg      <= min_idx_next;
        min_uses_reg     <= min_uses_next;
        min_page_reg     <= min_page_next;
        hit_reg          <= hit_next;
        evicted_reg      <= evicted_next;
        slot_reg         <= slot_next;
        evicted_page_reg <= evicted_page_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign fault         = !hit_reg;
    assign evicted_valid = evicted_reg;
    assign slot          = slot_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = faults_reg;

endmodule

>>> sim/lfu_tracker_pkg.sv
`timescale 1ns / 100ps
// Frame tracker for the LFU page replacement testbench: predicts each result item
// and checks the items the block returns. Depends on lfu_pkg for widths and types.
package lfu_tracker_pkg;

    import lfu_pkg::*;

    typedef struct packed {
        logic               hit;
        logic               fault;
        logic               evicted_valid;
        logic [SLOT_W-1:0]  slot;
        page_t              evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } page_outcome_t;

    class frame_tracker;
        page_t              frame_page [FRAMES];
        uses_t              frame_uses [FRAMES];
        int unsigned        frames_filled;
        logic [FAULT_W-1:0] faults_seen;
        logic [CFG_W-1:0]   frames_in_use;
        page_outcome_t      outcomes_due [$];
        int unsigned        mismatches;

        function new();
            frames_filled = 0;
            faults_seen   = '0;
            frames_in_use = CFG_W'(16);
            mismatches    = 0;
        endfunction

        function void write_limit(logic [CFG_W-1:0] value);
            frames_in_use = value;
        endfunction

        function int unsigned waiting();
            return outcomes_due.size();
        endfunction

        // Works out the result of one accepted page reference and queues it.
        function void reference_page(page_t page);
            page_outcome_t due;
            int unsigned   lim;
            int unsigned   idx;
            int unsigned   i;
            bit            found;
            due   = '0;
            found = 1'b0;
            idx   = 0;
            if (frames_in_use == 0)
                lim = 1;
            else if (frames_in_use > FRAMES)
                lim = FRAMES;
            else
                lim = frames_in_use;
            for (i = 0; i < frames_filled; i++)
            begin
                if (!found && frame_page[i] == page)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found)
            begin
                if (frame_uses[idx] != USE_MAX)
                    frame_uses[idx] = frame_uses[idx] + 1'b1;
                due.hit = 1'b1;
            end
            else
            begin
                if (frames_filled < lim)
                begin
                    idx = frames_filled;
                    frames_filled++;
                end
                else
                begin
                    // Least used occupied frame, lowest index on a tie.
                    idx = 0;
                    for (i = 1; i < frames_filled; i++)
                    begin
                        if (frame_uses[i] < frame_uses[idx])
                            idx = i;
                    end
                    due.evicted_valid = 1'b1;
                    due.evicted_page  = frame_page[idx];
                end
                frame_page[idx] = page;
                frame_uses[idx] = uses_t'(1);
                if (faults_seen != '1)
                    faults_seen = faults_seen + 1'b1;
                due.fault = 1'b1;
            end
            due.slot        = idx[SLOT_W-1:0];
            due.fault_total = faults_seen;
            outcomes_due.insert(outcomes_due.size(), due);
        endfunction

        // Compares a returned result item with the oldest one still due.
        function void compare_outcome(page_outcome_t got);
            page_outcome_t want;
            bit            bad;
            if (outcomes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with none due: hit=%0b fault=%0b slot=%0d total=%0d",
                             got.hit, got.fault, got.slot, got.fault_total);
                return;
            end
            want = outcomes_due.pop_front();
            bad  = (got.hit !== want.hit) || (got.fault !== want.fault)
                || (got.evicted_valid !== want.evicted_valid) || (got.slot !== want.slot)
                || (got.evicted_page !== want.evicted_page)
                || (got.fault_total !== want.fault_total);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected hit=%0b fault=%0b ev=%0b slot=%0d page=%h total=%0d",
                             want.hit, want.fault, want.evicted_valid, want.slot,
                             want.evicted_page, want.fault_total);
                    $display("          got      hit=%0b fault=%0b ev=%0b slot=%0d page=%h total=%0d",
                             got.hit, got.fault, got.evicted_valid, got.slot,
                             got.evicted_page, got.fault_total);
                end
            end
        endfunction
    endclass

endpackage

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for lfu_page_replacement: clock, reset, item drivers and the
// result monitor. Depends on lfu_pkg and on the frame tracker in lfu_tracker_pkg.
module testbench;

    import lfu_pkg::*;
    import lfu_tracker_pkg::*;

    // Far beyond the slowest correct run: some 730 references, plus input gaps
    // and receiver stalls.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    // Hits on one frame to lift its use count well above the others.
    localparam int unsigned HOT_HITS = 20;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    page_t              page_address;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;
    logic               fault;
    logic               evicted_valid;
    logic [SLOT_W-1:0]  slot;
    page_t              evicted_page;
    logic [FAULT_W-1:0] fault_total;

    frame_tracker  tracker;
    page_outcome_t seen_result;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left = 0;
    // When idle_on is clear, neither side inserts gaps or stalls.
    bit            idle_on = 1'b0;

    lfu_page_replacement dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_address  (page_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .fault         (fault),
        .evicted_valid (evicted_valid),
        .slot          (slot),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    always #1 clk = ~clk;

    // Runaway guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver back-pressure in random stall bursts. It is driven at the falling
    // edge so the block sees a settled value at the rising edge.
    always @(negedge clk)
    begin
        if (idle_on && stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor. Values are read at the rising edge, before any of the
    // block's registers update in the same time step.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result.hit           = hit;
            seen_result.fault         = fault;
            seen_result.evicted_valid = evicted_valid;
            seen_result.slot          = slot;
            seen_result.evicted_page  = evicted_page;
            seen_result.fault_total   = fault_total;
            tracker.compare_outcome(seen_result);
        end
    end

    // Presents one page reference item and returns at the falling edge after
    // it has been taken. Valid is left high, so a following call keeps it up
    // without a drop; the caller lowers it when the burst ends.
    task automatic send_page(input page_t page);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        page_address <= page;
        do
            @(posedge clk);
        while (in_stall);
        tracker.reference_page(page);
        @(negedge clk);
    endtask

    // Lowers valid and waits until every expected result item has come back,
    // which leaves the block idle since each reference gives exactly one result.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.waiting() != 0)
            @(negedge clk);
    endtask

    // Writes frames_in_use; only ever called with the block idle.
    task automatic write_limit_reg(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_limit(value);
    endtask

    // One random phase under a given frame limit. Most references come from a
    // small pool, partly made of pages already resident, so that hits, fills
    // and evictions all occur; the pool pick is skewed so use counts differ.
    task automatic run_phase(input logic [CFG_W-1:0] limit, input int unsigned count,
                             input bit allow_idle);
        page_t       pool [24];
        int unsigned span;
        int unsigned pick;
        int unsigned k;
        settle();
        write_limit_reg(limit);
        idle_on = allow_idle && ($urandom_range(0, 2) != 0);
        span    = $urandom_range(4, 22);
        for (k = 0; k < 24; k++)
        begin
            if (k < span / 2 && tracker.frames_filled > 0)
                pool[k] = tracker.frame_page[k % tracker.frames_filled];
            else
                pool[k] = $urandom;
        end
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                pick = $urandom_range(0, span - 1);
                if ($urandom_range(0, 1) == 1)
                    pick = pick / 2;
                send_page(pool[pick]);
            end
            else
                send_page($urandom);
        end
    endtask

    initial
    begin
        page_t hot_page;
        tracker      = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        page_address = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset limit of sixteen: both extreme addresses,
        // repeated hits to build up differing use counts, and alternating bits.
        idle_on = 1'b1;
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'h0000_0000);
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'hAAAA_AAAA);
        send_page(32'h5555_5555);

        // A limit of zero acts as one and sits below the present occupancy, so
        // each miss replaces the least used frame among all occupied ones.
        settle();
        write_limit_reg(CFG_W'(0));
        send_page(32'h0000_0001);
        send_page(32'h0000_0002);
        send_page(32'h0000_0000);
        send_page(32'h0000_0001);

        // The largest register value is clamped to sixteen, so filling resumes.
        settle();
        write_limit_reg(CFG_W'(31));
        send_page(32'h0000_0003);
        send_page(32'h0000_0004);
        send_page(32'h0000_0005);

        // Just above the frame count, also clamped.
        settle();
        write_limit_reg(CFG_W'(17));
        send_page(32'h0000_0006);
        send_page(32'h0000_0003);

        // Random phases over limits that rise and fall, so occupancy grows in
        // steps and is often left above the limit.
        run_phase(CFG_W'(2), 70, 1'b1);
        run_phase(CFG_W'(9), 70, 1'b1);
        run_phase(CFG_W'(1), 70, 1'b1);
        run_phase(CFG_W'(12), 70, 1'b1);
        run_phase(CFG_W'(0), 70, 1'b1);
        run_phase(CFG_W'(16), 70, 1'b1);
        run_phase(CFG_W'(3), 70, 1'b1);
        run_phase(CFG_W'(31), 70, 1'b1);
        run_phase(CFG_W'($urandom_range(0, 31)), 70, 1'b1);

        // Final part without any idling. First the page in frame zero is hit
        // a number of times so its use count stands above the rest; the misses
        // that follow must then pass it over while a less used frame exists.
        settle();
        idle_on  = 1'b0;
        hot_page = tracker.frame_page[0];
        repeat (HOT_HITS) send_page(hot_page);
        run_phase(CFG_W'(5), 60, 1'b0);
        settle();

        // Allow for any stray result item the block might still produce.
        repeat (30) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
